FILE: src/imu_pkg.sv
// shared types, constants and the arctangent step table
package imu_pkg;

  localparam int AVG_DEPTH  = 5;
  localparam int ANGLE_ITER = 16;
  localparam int SLOT_W     = $clog2(AVG_DEPTH);
  localparam int ITER_W     = $clog2(ANGLE_ITER);
  localparam int SUM_W      = 19;
  localparam int MEAN_W     = 17;
  localparam int CW         = 33;

  localparam logic [14:0] LIMIT_RESET = 15'd30720;
  localparam logic [14:0] RATE_SCALE  = 15'd14667;
  localparam logic [17:0] DIV5_MUL    = 18'd209716;
  localparam logic [15:0] RIGHT_ANGLE = 16'd23040;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_z;
    logic signed [SUM_W-1:0] sum_r;
  } sums_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_ROT,
    BK_ROLL,
    BK_PINIT,
    BK_PITCH,
    BK_PFIN,
    BK_OUT
  } back_state_e;

  typedef logic signed [CW-1:0] ang_tab_t [ANGLE_ITER];

  // shift-subtract quotient of two non-negative constants
  function automatic longint const_div(input longint num, input longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & longint'(1));
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (longint'(1) << b);
      end
    end
    return quo;
  endfunction

  function automatic ang_tab_t build_tab();
    ang_tab_t tab;
    longint   rad;
    longint   term;
    longint   e;
    tab[0] = CW'(64'd45 * 64'd256 * 64'd65536);
    for (int i = 1; i < ANGLE_ITER; i++) begin
      rad = 0;
      for (int k = 0; i * (2 * k + 1) <= 32; k++) begin
        e    = 32 - i * (2 * k + 1);
        term = const_div(longint'(1) << e, longint'(2 * k + 1));
        rad  = ((k & 1) == 1) ? rad - term : rad + term;
      end
      tab[i] = CW'((64'(rad) * 64'd961263669 + 64'h80000000) >> 32);
    end
    return tab;
  endfunction

  localparam ang_tab_t ATAN_TAB = build_tab();

endpackage

FILE: src/imu_front.sv
// front end: limit check, sample ring and running channel sums
module imu_front import imu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [14:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] yaw_rate_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output sums_t              q_data_o
);

  logic [14:0]        limit_q;
  logic signed [15:0] ring_x_q [AVG_DEPTH];
  logic signed [15:0] ring_y_q [AVG_DEPTH];
  logic signed [15:0] ring_z_q [AVG_DEPTH];
  logic signed [16:0] ring_r_q [AVG_DEPTH];
  logic [SLOT_W-1:0]  slot_q;
  sums_t              sums_q, sums_d;
  logic signed [15:0] lim_s;
  logic signed [16:0] rate_neg;
  logic               xfer, keep;

  assign lim_s    = $signed({1'b0, limit_q});
  assign rate_neg = -17'(yaw_rate_i);
  assign xfer     = in_valid_i && !q_full_i;
  assign keep     = !(accel_x_i > lim_s || accel_y_i > lim_s || accel_z_i > lim_s);
  assign in_stall_o = q_full_i;
  assign q_push_o   = xfer && keep;

  always_comb begin
    sums_d.sum_x = sums_q.sum_x + SUM_W'(accel_x_i) - SUM_W'(ring_x_q[slot_q]);
    sums_d.sum_y = sums_q.sum_y + SUM_W'(accel_y_i) - SUM_W'(ring_y_q[slot_q]);
    sums_d.sum_z = sums_q.sum_z + SUM_W'(accel_z_i) - SUM_W'(ring_z_q[slot_q]);
    sums_d.sum_r = sums_q.sum_r + SUM_W'(rate_neg) - SUM_W'(ring_r_q[slot_q]);
  end

  assign q_data_o = sums_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      slot_q  <= '0;
      sums_q  <= '0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_x_q[i] <= '0;
        ring_y_q[i] <= '0;
        ring_z_q[i] <= '0;
        ring_r_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (xfer && keep) begin
        ring_x_q[slot_q] <= accel_x_i;
        ring_y_q[slot_q] <= accel_y_i;
        ring_z_q[slot_q] <= accel_z_i;
        ring_r_q[slot_q] <= rate_neg;
        sums_q <= sums_d;
        slot_q <= (slot_q == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_q + 1'b1;
      end
    end
  end

endmodule

FILE: src/imu_queue.sv
// two-entry queue of channel sums between front and back
module imu_queue import imu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  sums_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output sums_t rdata_o
);

  sums_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

FILE: src/imu_back.sv
// back end: averages, rotation scaling and shared cordic arctangent
module imu_back import imu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  sums_t              q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] rotation_rate_o,
  output logic signed [15:0] mean_accel_x_o,
  output logic signed [15:0] mean_accel_y_o,
  output logic signed [15:0] mean_accel_z_o,
  output logic signed [15:0] mean_rate_o
);

  back_state_e state_q, state_d;
  sums_t       sums_q;
  logic signed [MEAN_W-1:0] mx_q, my_q, mz_q, mr_q;
  logic signed [32:0]       prod_q;
  logic signed [CW-1:0]     x_q, y_q, z_q, dx, dy, x_n, y_n, z_n;
  logic [ITER_W-1:0]        iter_q;
  logic                     num0_q, den0_q, numneg_q, neg_q;
  logic signed [15:0]       roll_q, pitch_q, ang_fin;
  logic                     last_iter;

  function automatic logic signed [MEAN_W-1:0] div5(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-2:0] mag;
    logic [35:0]      p;
    logic [15:0]      q;
    mag = s[SUM_W-1] ? (SUM_W-1)'(-s) : s[SUM_W-2:0];
    p   = 36'(mag) * 36'(DIV5_MUL);
    q   = p[35:20];
    return s[SUM_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  assign last_iter = (iter_q == ITER_W'(ANGLE_ITER - 1));

  // cordic vectoring step
  always_comb begin
    dx = y_q >>> iter_q;
    dy = x_q >>> iter_q;
    if (y_q > 0) begin
      x_n = x_q + dx;
      y_n = y_q - dy;
      z_n = z_q + ATAN_TAB[iter_q];
    end else begin
      x_n = x_q - dx;
      y_n = y_q + dy;
      z_n = z_q - ATAN_TAB[iter_q];
    end
  end

  // angle finish: clamp, round, sign, special cases
  always_comb begin
    logic signed [CW-1:0] zc;
    logic [CW-1:0]        r;
    logic [15:0]          mag;
    if (z_q < 0) begin
      zc = '0;
    end else if (z_q > $signed(CW'({RIGHT_ANGLE, 16'd0}))) begin
      zc = CW'({RIGHT_ANGLE, 16'd0});
    end else begin
      zc = z_q;
    end
    r   = CW'(zc) + CW'(32768);
    mag = r[31:16];
    if (mag > RIGHT_ANGLE) begin
      mag = RIGHT_ANGLE;
    end
    if (num0_q) begin
      ang_fin = '0;
    end else if (den0_q) begin
      ang_fin = numneg_q ? -$signed(RIGHT_ANGLE) : $signed(RIGHT_ANGLE);
    end else begin
      ang_fin = neg_q ? -$signed(mag) : $signed(mag);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:  if (q_valid_i) state_d = BK_DIV;
      BK_DIV:   state_d = BK_ROT;
      BK_ROT:   state_d = BK_ROLL;
      BK_ROLL:  if (last_iter) state_d = BK_PINIT;
      BK_PINIT: state_d = BK_PITCH;
      BK_PITCH: if (last_iter) state_d = BK_PFIN;
      BK_PFIN:  state_d = BK_OUT;
      BK_OUT:   if (!out_stall_i) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o     = (state_q == BK_IDLE) && q_valid_i;
    out_valid_o = (state_q == BK_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          sums_q <= q_data_i;
        end
      end
      BK_DIV: begin
        mx_q <= div5(sums_q.sum_x);
        my_q <= div5(sums_q.sum_y);
        mz_q <= div5(sums_q.sum_z);
        mr_q <= div5(sums_q.sum_r);
      end
      BK_ROT, BK_PINIT: begin
        if (state_q == BK_ROT) begin
          prod_q <= $signed(mr_q) * $signed({1'b0, RATE_SCALE});
          num0_q   <= (mx_q == 0);
          numneg_q <= mx_q[MEAN_W-1];
          neg_q    <= mx_q[MEAN_W-1] != mz_q[MEAN_W-1];
          y_q <= CW'($signed({mx_q[MEAN_W-1] ? -mx_q : mx_q, 14'd0}));
        end else begin
          roll_q   <= ang_fin;
          num0_q   <= (my_q == 0);
          numneg_q <= my_q[MEAN_W-1];
          neg_q    <= my_q[MEAN_W-1] != mz_q[MEAN_W-1];
          y_q <= CW'($signed({my_q[MEAN_W-1] ? -my_q : my_q, 14'd0}));
        end
        den0_q <= (mz_q == 0);
        x_q    <= CW'($signed({mz_q[MEAN_W-1] ? -mz_q : mz_q, 14'd0}));
        z_q    <= '0;
        iter_q <= '0;
      end
      BK_ROLL, BK_PITCH: begin
        x_q    <= x_n;
        y_q    <= y_n;
        z_q    <= z_n;
        iter_q <= iter_q + 1'b1;
      end
      BK_PFIN: begin
        pitch_q <= ang_fin;
      end
      BK_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign roll_angle_o    = roll_q;
  assign pitch_angle_o   = pitch_q;
  assign rotation_rate_o = prod_q[29:14];
  assign mean_accel_x_o  = mx_q[15:0];
  assign mean_accel_y_o  = my_q[15:0];
  assign mean_accel_z_o  = mz_q[15:0];
  assign mean_rate_o     = (mr_q > $signed(MEAN_W'(32767))) ? 16'sd32767 : mr_q[15:0];

endmodule

FILE: src/imu_tilt_from_moving_average_unit.sv
// top level: imu tilt and rotation from a five-sample moving average
// the back end takes new sums only once its result is out, since
// the two 16-step cordic passes share one arctangent unit; the front
// takes samples into a two-entry queue
// reset: ring, sums and slot cleared, limit set to 30720, no result pending
module imu_tilt_from_moving_average_unit import imu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [14:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] yaw_rate_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] rotation_rate_o,
  output logic signed [15:0] mean_accel_x_o,
  output logic signed [15:0] mean_accel_y_o,
  output logic signed [15:0] mean_accel_z_o,
  output logic signed [15:0] mean_rate_o
);

  logic  push, full, pop, qv;
  sums_t wdata, rdata;

  imu_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .accel_x_i, .accel_y_i, .accel_z_i, .yaw_rate_i,
    .q_full_i(full), .q_push_o(push), .q_data_o(wdata)
  );

  imu_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(wdata), .full_o(full),
    .pop_i(pop), .valid_o(qv), .rdata_o(rdata)
  );

  imu_back u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_data_i(rdata), .q_pop_o(pop),
    .out_valid_o, .out_stall_i, .roll_angle_o, .pitch_angle_o, .rotation_rate_o,
    .mean_accel_x_o, .mean_accel_y_o, .mean_accel_z_o, .mean_rate_o
  );

endmodule
